/* hw/rtl/b64d_pkg.sv */
// b64d_pkg: types, constants and helper functions of the lenient base64 decoder
// used by base64_decoder_lenient_core; depends on nothing else

package b64d_pkg;

   // character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // alphabet offsets of the lower-case letters and the digits
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;

   // sextet lookup result: top bit set for a character outside the alphabet
   localparam logic [6:0] SEXTET_INVALID = 7'h40;
   localparam logic [6:0] SEXTET_PLUS    = 7'd62;
   localparam logic [6:0] SEXTET_SLASH   = 7'd63;

   // sextets held before a group completes
   localparam int HELD_DEPTH = 3;

   // decoded bytes of one input item, waiting to go out one per transfer
   typedef struct packed {
      logic [2:0][7:0] data;       // bytes in output order, entry 0 first
      logic [1:0]      last_idx;   // index of the final byte of the bundle
      logic            data_valid; // 0 for a bare end-of-message marker
      logic            done;       // final byte closes the message
   } b64d_bundle_type;

   // map one character to its sextet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] s;
      s = SEXTET_INVALID;
      case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: s = {1'b0, 6'(c - CHAR_UPPER_A)};
         [CHAR_LOWER_A:CHAR_LOWER_Z]: s = {1'b0, 6'(c - CHAR_LOWER_A + LOWER_BASE)};
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: s = {1'b0, 6'(c - CHAR_DIGIT_0 + DIGIT_BASE)};
         CHAR_PLUS:                   s = SEXTET_PLUS;
         CHAR_SLASH:                  s = SEXTET_SLASH;
         default:                     s = SEXTET_INVALID;
      endcase
      return s;
   endfunction

   // byte assembly from sextet pairs
   function automatic logic [7:0] byte0(input logic [5:0] a, input logic [5:0] b);
      return {a, b[5:4]};
   endfunction

   function automatic logic [7:0] byte1(input logic [5:0] b, input logic [5:0] c);
      return {b[3:0], c[5:2]};
   endfunction

   function automatic logic [7:0] byte2(input logic [5:0] c, input logic [5:0] d);
      return {c[1:0], d};
   endfunction

endpackage

/* hw/rtl/base64_decoder_lenient_core.sv */
// base64_decoder_lenient_core: lenient base64 decoder, one character per transfer
// depends on b64d_pkg
//
//   channel | direction | tdata          | tlast        | tuser
//   req_    | in        | in_char        | message_end  | -
//   rsp_    | out       | out_byte       | last_of_run  | byte_valid, message_done
//
// one character is taken per cycle while req_tready is high; decode is a single
// pass from the accepted character and the group state into a bundle register
// a bundle of up to three bytes drains at one byte per cycle while rsp_tready is
// high, from a two-slot queue; req_tready drops only while the second slot is
// occupied; group state is registered at the transfer, results are registered in the queue
// reset (synchronous, active high) empties the queue and clears the group state
// a stalled rsp_ side holds the current byte and fills the second slot first

module base64_decoder_lenient_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // message_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic [1:0] rsp_tuser    // [0] byte_valid, [1] message_done
);
   import b64d_pkg::*;

   // decoder state
   logic [1:0]       group_count_ff, group_count_in;
   logic [5:0]       held_ff [HELD_DEPTH];
   logic [5:0]       held_in [HELD_DEPTH];
   logic             pad_seen_ff, pad_seen_in;

   // result queue
   b64d_bundle_type  head_ff, head_in, spare_ff, spare_in;
   logic             head_valid_ff, head_valid_in;
   logic             spare_valid_ff, spare_valid_in;
   logic [1:0]       idx_ff, idx_in;

   // decode signals
   logic             req_xfer, rsp_xfer;
   logic [6:0]       sextet;
   b64d_bundle_type  new_bundle;
   logic             new_push;
   logic             head_pop;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign sextet   = sextet_of(req_tdata);

   // decode of the accepted character
   always_comb begin
      group_count_in        = group_count_ff;
      held_in               = held_ff;
      pad_seen_in           = pad_seen_ff;
      new_bundle.data       = '0;
      new_bundle.last_idx   = '0;
      new_bundle.data_valid = 1'b1;
      new_bundle.done       = 1'b0;
      new_push              = 1'b0;
      if (req_xfer) begin
         // alphabet characters until the first pad
         if (!pad_seen_ff) begin
            if (req_tdata == CHAR_PAD) begin
               pad_seen_in = 1'b1;
            end else if (!sextet[6]) begin
               if (group_count_ff != 2'd3) begin
                  held_in[group_count_ff] = sextet[5:0];
                  group_count_in          = group_count_ff + 2'd1;
               end else begin
                  new_bundle.data[0]  = byte0(held_ff[0], held_ff[1]);
                  new_bundle.data[1]  = byte1(held_ff[1], held_ff[2]);
                  new_bundle.data[2]  = byte2(held_ff[2], sextet[5:0]);
                  new_bundle.last_idx = 2'd2;
                  new_push            = 1'b1;
                  group_count_in      = 2'd0;
               end
            end
         end
         // message end: flush a partial group, give a bare marker, or mark the completed group as the end
         if (req_tlast) begin
            if (!new_push) begin
               new_push = 1'b1;
               if (group_count_in == 2'd3) begin
                  new_bundle.data[0]  = byte0(held_in[0], held_in[1]);
                  new_bundle.data[1]  = byte1(held_in[1], held_in[2]);
                  new_bundle.last_idx = 2'd1;
               end else if (group_count_in == 2'd2) begin
                  new_bundle.data[0]  = byte0(held_in[0], held_in[1]);
               end else begin
                  new_bundle.data_valid = 1'b0;
               end
            end
            new_bundle.done = 1'b1;
            group_count_in  = 2'd0;
            pad_seen_in     = 1'b0;
         end
      end
   end

   // queue control: head drains one byte per transfer, spare waits behind it
   assign head_pop   = rsp_xfer && (idx_ff == head_ff.last_idx);
   assign req_tready = !spare_valid_ff;

   always_comb begin
      head_in        = head_ff;
      spare_in       = spare_ff;
      head_valid_in  = head_valid_ff;
      spare_valid_in = spare_valid_ff;
      idx_in         = idx_ff;
      if (rsp_xfer && !head_pop) begin
         idx_in = idx_ff + 2'd1;
      end
      if (head_pop) begin
         idx_in         = 2'd0;
         head_in        = spare_ff;
         head_valid_in  = spare_valid_ff;
         spare_valid_in = 1'b0;
      end
      if (new_push) begin
         if (!head_valid_ff || (head_pop && !spare_valid_ff)) begin
            head_in       = new_bundle;
            head_valid_in = 1'b1;
         end else begin
            spare_in       = new_bundle;
            spare_valid_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff <= 2'd0;
         pad_seen_ff    <= 1'b0;
         head_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
         idx_ff         <= 2'd0;
      end else begin
         group_count_ff <= group_count_in;
         pad_seen_ff    <= pad_seen_in;
         head_valid_ff  <= head_valid_in;
         spare_valid_ff <= spare_valid_in;
         idx_ff         <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   // output side
   assign rsp_tvalid   = head_valid_ff;
   assign rsp_tdata    = head_ff.data[idx_ff];
   assign rsp_tlast    = (idx_ff == head_ff.last_idx);
   assign rsp_tuser[0] = head_ff.data_valid;
   assign rsp_tuser[1] = head_ff.done && (idx_ff == head_ff.last_idx);

   // spare slot is only filled behind an occupied head
   assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> head_valid_ff)
      else $error("spare bundle without head bundle");

   // byte index stays inside the head bundle
   assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> (idx_ff <= head_ff.last_idx))
      else $error("byte index past end of bundle");

   // message end clears the group state
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (group_count_ff == 2'd0 && !pad_seen_ff))
      else $error("group state not cleared at message end");

   // a bare marker is always a single result that closes the message
   assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && !head_ff.data_valid) |->
         (head_ff.done && head_ff.last_idx == 2'd0))
      else $error("malformed end-of-message marker");

endmodule
